// ----- rtl/pwm_pdr_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty rescaler package
// Transfer types, operation codes and prescaler constants shared by the
// rescaler RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package pwm_pdr_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_DUTY = 2'd0,
        FUNC_READ_DUTY  = 2'd1,
        FUNC_SET_PERIOD = 2'd2,
        FUNC_SET_PULSE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] duty_read;
        logic [15:0] top_now;
        logic [15:0] compare_now;
        logic [2:0]  clock_select_now;
    } t_out_item;

    localparam logic [15:0] FULL_SCALE = 16'hffff;
    localparam logic [2:0]  CS_MASK    = 3'h7;
    localparam logic [2:0]  CS_FIRST   = 3'd1;
    localparam logic [2:0]  CS_LAST    = 3'd5;
    localparam logic [2:0]  CS_RESET   = 3'd2;
    localparam logic [7:0]  STOP_SHIFT = 8'hff;
    localparam logic [7:0]  SHIFT_LIMIT = 8'h10 + 8'h10;

    // Prescale shift for each clock-select code; code 0 stops the clock.
    localparam logic [7:0] SHIFT_OF_CODE [8] = '{
        8'hff, 8'd0, 8'd3, 8'd6, 8'd8, 8'd10, 8'd0, 8'd0
    };

endpackage

`default_nettype wire

// ----- rtl/pwm_period_duty_rescaler.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty rescaler
// Holds the compare, top and clock-select values of a 16-bit PWM timer and
// performs duty writes and reads, period changes and pulse-width writes with
// a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  request   in         i_valid / o_stall    i_in  (func, value)
//  result    out        o_valid / i_stall    o_out (duty, top, compare, select)
//
// Read duty divides unless compare has reached top; write duty multiplies,
// then divides; set period does the same after a first division, which is
// skipped when compare has reached top; pulse width does neither. A 16-step
// shift-and-add multiplier and shift-and-subtract divider share r_hi and r_lo.
// A request is taken only while the sequencer is idle; a result waits in the
// output register while the downstream side stalls. Reset is synchronous and
// restores compare 0, the default top and divide-by-eight.
//
`default_nettype none

module pwm_period_duty_rescaler #(
    parameter int DEFAULT_TOP = 20000
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire pwm_pdr_pkg::t_in_item i_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output pwm_pdr_pkg::t_out_item     o_out
);

    localparam logic [15:0] TOP_RESET = 16'(DEFAULT_TOP);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RDIV = 5'b00010,
        S_MUL  = 5'b00100,
        S_WDIV = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_ovalid, n_ovalid;
    pwm_pdr_pkg::t_out_item r_out, n_out;
    logic [15:0]            r_cmp, n_cmp;
    logic [15:0]            r_top, n_top;
    logic [2:0]             r_cs, n_cs;
    logic [15:0]            r_hi, n_hi;
    logic [15:0]            r_lo, n_lo;
    logic [15:0]            r_div, n_div;
    logic [15:0]            r_duty, n_duty;
    logic [3:0]             r_cnt, n_cnt;
    pwm_pdr_pkg::t_func     r_op, n_op;

    logic        take;
    logic        cmp_sat;
    logic [31:0] read_dvd;
    logic [16:0] div_trial;
    logic [16:0] div_diff;
    logic        div_ge;
    logic [15:0] div_hi;
    logic [15:0] div_lo;
    logic [16:0] mul_sum;
    logic [15:0] per_top;
    logic [2:0]  per_cs;
    logic [7:0]  pulse_shift;
    logic [31:0] pulse_raw;
    logic [15:0] pulse_val;

    assign o_stall = (r_state != S_IDLE);
    assign take    = i_valid && (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // The duty is saturated whenever compare has reached top, which also
    // covers a zero top.
    assign cmp_sat  = (r_cmp >= r_top);
    assign read_dvd = {r_cmp, 16'h0000} - {16'h0000, r_cmp};

    // One restoring division step: the high half is the partial remainder,
    // the low half shifts out dividend bits and shifts in quotient bits.
    assign div_trial = {r_hi, r_lo[15]};
    assign div_diff  = div_trial - {1'b0, r_div};
    assign div_ge    = (div_trial >= {1'b0, r_div});
    assign div_hi    = div_ge ? div_diff[15:0] : div_trial[15:0];
    assign div_lo    = {r_lo[14:0], div_ge};

    // One shift-and-add step: the multiplier sits in the low half and the
    // product grows into the high half from the top.
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_top} : 17'd0);

    // The lowest clock-select code whose prescaler brings the period within 16 bits wins.
    always_comb begin
        logic [31:0] scaled;
        per_top = pwm_pdr_pkg::FULL_SCALE;
        per_cs  = pwm_pdr_pkg::CS_LAST;
        for (int k = 5; k >= 1; k--) begin
            scaled = i_in.value >> pwm_pdr_pkg::SHIFT_OF_CODE[3'(k)][4:0];
            if (scaled[31:16] == 16'h0000) begin
                per_top = scaled[15:0];
                per_cs  = 3'(k);
            end
        end
    end

    always_comb begin
        pulse_shift = pwm_pdr_pkg::SHIFT_OF_CODE[r_cs & pwm_pdr_pkg::CS_MASK];
        if (pulse_shift == pwm_pdr_pkg::STOP_SHIFT
                || pulse_shift >= pwm_pdr_pkg::SHIFT_LIMIT) begin
            pulse_raw = 32'h0;
        end else begin
            pulse_raw = i_in.value >> pulse_shift[4:0];
        end
        pulse_val = (pulse_raw[31:16] != 16'h0000) ? pwm_pdr_pkg::FULL_SCALE
                                                   : pulse_raw[15:0];
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_cmp    = r_cmp;
        n_top    = r_top;
        n_cs     = r_cs;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_div    = r_div;
        n_duty   = r_duty;
        n_cnt    = r_cnt;
        n_op     = r_op;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_op   = i_in.func;
                    n_duty = 16'h0000;
                    n_cnt  = 4'd0;
                    unique case (i_in.func)
                        pwm_pdr_pkg::FUNC_WRITE_DUTY: begin
                            n_hi    = 16'h0000;
                            n_lo    = i_in.value[15:0];
                            n_state = S_MUL;
                        end
                        pwm_pdr_pkg::FUNC_READ_DUTY: begin
                            if (cmp_sat) begin
                                n_duty  = pwm_pdr_pkg::FULL_SCALE;
                                n_state = S_DONE;
                            end else begin
                                n_hi    = read_dvd[31:16];
                                n_lo    = read_dvd[15:0];
                                n_div   = r_top;
                                n_state = S_RDIV;
                            end
                        end
                        pwm_pdr_pkg::FUNC_SET_PERIOD: begin
                            // The old duty is read against the old top, which
                            // the divisor register keeps.
                            n_top = per_top;
                            n_cs  = per_cs;
                            if (cmp_sat) begin
                                n_hi    = 16'h0000;
                                n_lo    = pwm_pdr_pkg::FULL_SCALE;
                                n_state = S_MUL;
                            end else begin
                                n_hi    = read_dvd[31:16];
                                n_lo    = read_dvd[15:0];
                                n_div   = r_top;
                                n_state = S_RDIV;
                            end
                        end
                        pwm_pdr_pkg::FUNC_SET_PULSE: begin
                            n_cmp   = pulse_val;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RDIV: begin
                n_hi  = div_hi;
                n_lo  = div_lo;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'hf) begin
                    if (r_op == pwm_pdr_pkg::FUNC_READ_DUTY) begin
                        n_duty  = div_lo;
                        n_state = S_DONE;
                    end else begin
                        // The quotient becomes the multiplier for the new top.
                        n_hi    = 16'h0000;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_hi  = mul_sum[16:1];
                n_lo  = {mul_sum[0], r_lo[15:1]};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'hf) begin
                    n_div   = pwm_pdr_pkg::FULL_SCALE;
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                n_hi  = div_hi;
                n_lo  = div_lo;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'hf) begin
                    n_cmp   = div_lo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid               = 1'b1;
                    n_out.duty_read        = r_duty;
                    n_out.top_now          = r_top;
                    n_out.compare_now      = r_cmp;
                    n_out.clock_select_now = r_cs;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cmp    <= 16'h0000;
            r_top    <= TOP_RESET;
            r_cs     <= pwm_pdr_pkg::CS_RESET;
            r_cnt    <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cmp    <= n_cmp;
            r_top    <= n_top;
            r_cs     <= n_cs;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_div  <= n_div;
        r_duty <= n_duty;
        r_op   <= n_op;
    end

endmodule

`default_nettype wire

// ----- bench/pwm_period_duty_rescaler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM period and duty rescaler testbench
// Sends duty writes and reads, period changes and pulse-width writes through
// the request channel, predicts each result from its own model of the
// compare, top and clock-select values, and checks every result transfer
// field by field under random idling and output back-pressure.
// ----------------------------------------------------------------------------

module pwm_period_duty_rescaler_tb;

    localparam int DEFAULT_TOP          = 20000;
    localparam int RESET_CYCLES         = 5;
    localparam int IDLE_PERCENT         = 32;
    localparam int HOLD_OFF_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT       = 2000;
    localparam int TAIL_CYCLES          = 60;
    localparam int MISMATCH_PRINT_LIMIT = 200;

    localparam logic [15:0] DUTY_FULL = 16'hffff;
    localparam logic [31:0] TOP_LIMIT = 32'd65535;

    // Clock-select codes.
    localparam logic [2:0] SEL_STOPPED  = 3'd0;
    localparam logic [2:0] SEL_DIV1     = 3'd1;
    localparam logic [2:0] SEL_DIV8     = 3'd2;
    localparam logic [2:0] SEL_DIV64    = 3'd3;
    localparam logic [2:0] SEL_DIV256   = 3'd4;
    localparam logic [2:0] SEL_DIV1024  = 3'd5;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    pwm_pdr_pkg::t_in_item  i_in    = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    pwm_pdr_pkg::t_out_item o_out;

    // Timer state as the block should hold it.
    logic [15:0] model_compare = 16'd0;
    logic [15:0] model_top     = 16'(DEFAULT_TOP);
    logic [2:0]  model_select  = SEL_DIV8;

    pwm_pdr_pkg::t_out_item pending_results [$];

    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  requests_sent   = 0;
    int  op_count [4]    = '{0, 0, 0, 0};
    bit  tx_idle_on      = 1'b1;
    bit  rx_idle_on      = 1'b1;
    int  hold_off_trigger = 0;
    int  hold_off_seen    = 0;
    int  hold_left        = 0;

    pwm_period_duty_rescaler #(
        .DEFAULT_TOP(DEFAULT_TOP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] prescaled_cycles(input logic [31:0] cycles,
                                                     input logic [2:0] sel);
        case (sel)
            SEL_STOPPED: return 32'd0;
            SEL_DIV8:    return cycles >> 3;
            SEL_DIV64:   return cycles >> 6;
            SEL_DIV256:  return cycles >> 8;
            SEL_DIV1024: return cycles >> 10;
            default:     return cycles;
        endcase
    endfunction

    function automatic logic [15:0] duty_from_state();
        logic [31:0] scaled;
        if (model_compare >= model_top) return DUTY_FULL;
        scaled = ({16'd0, model_compare} * {16'd0, DUTY_FULL}) / {16'd0, model_top};
        return scaled[15:0];
    endfunction

    function automatic logic [15:0] compare_for_duty(input logic [15:0] duty);
        logic [31:0] scaled;
        scaled = ({16'd0, duty} * {16'd0, model_top}) / {16'd0, DUTY_FULL};
        return scaled[15:0];
    endfunction

    function automatic pwm_pdr_pkg::t_out_item predict_result(
            input pwm_pdr_pkg::t_in_item req);
        pwm_pdr_pkg::t_out_item res;
        logic [15:0] duty;
        logic [31:0] scaled;
        logic [15:0] new_top;
        logic [2:0]  new_sel;
        bit          found;
        res = '0;
        case (req.func)
            pwm_pdr_pkg::FUNC_WRITE_DUTY:
                model_compare = compare_for_duty(req.value[15:0]);
            pwm_pdr_pkg::FUNC_READ_DUTY:
                res.duty_read = duty_from_state();
            pwm_pdr_pkg::FUNC_SET_PERIOD: begin
                // First prescaler that brings the top within 16 bits wins;
                // otherwise the slowest one with a full-scale top.
                found   = 1'b0;
                new_top = DUTY_FULL;
                new_sel = SEL_DIV1024;
                for (int c = int'(SEL_DIV1); c <= int'(SEL_DIV1024); c++) begin
                    scaled = prescaled_cycles(req.value, c[2:0]);
                    if (!found && scaled <= TOP_LIMIT) begin
                        found   = 1'b1;
                        new_top = scaled[15:0];
                        new_sel = c[2:0];
                    end
                end
                duty          = duty_from_state();
                model_top     = new_top;
                model_select  = new_sel;
                model_compare = compare_for_duty(duty);
            end
            default: begin
                scaled        = prescaled_cycles(req.value, model_select);
                model_compare = (scaled > TOP_LIMIT) ? DUTY_FULL : scaled[15:0];
            end
        endcase
        res.top_now          = model_top;
        res.compare_now      = model_compare;
        res.clock_select_now = model_select;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Entered just after a falling edge; returns just after a falling edge
    // with valid still high, which a drain or an idle turn of the next call lowers.
    task automatic send_request(input pwm_pdr_pkg::t_func op, input logic [31:0] arg);
        pwm_pdr_pkg::t_in_item req;
        req.func  = op;
        req.value = arg;
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= req;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_result(req));
        requests_sent++;
        op_count[op]++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [31:0] period_near_edge();
        logic [31:0] edge_value;
        case ($urandom_range(0, 4))
            0:       edge_value = 32'h0001_0000;
            1:       edge_value = 32'h0001_0000 << 3;
            2:       edge_value = 32'h0001_0000 << 6;
            3:       edge_value = 32'h0001_0000 << 8;
            default: edge_value = 32'h0001_0000 << 10;
        endcase
        return edge_value + $urandom_range(0, 4) - 2;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_off_trigger != hold_off_seen) begin
            hold_off_seen = hold_off_trigger;
            hold_left     = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        // A badly broken block would otherwise flood the log.
        if (mismatch_count <= MISMATCH_PRINT_LIMIT)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        pwm_pdr_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result transfer", 32'd0,
                                32'(o_out.top_now));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out.duty_read !== want.duty_read)
                    report_mismatch("duty_read", 32'(want.duty_read),
                                    32'(o_out.duty_read));
                if (o_out.top_now !== want.top_now)
                    report_mismatch("top_now", 32'(want.top_now), 32'(o_out.top_now));
                if (o_out.compare_now !== want.compare_now)
                    report_mismatch("compare_now", 32'(want.compare_now),
                                    32'(o_out.compare_now));
                if (o_out.clock_select_now !== want.clock_select_now)
                    report_mismatch("clock_select_now", 32'(want.clock_select_now),
                                    32'(o_out.clock_select_now));
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timed out after %0d cycles without a transfer.", WATCHDOG_LIMIT);
        $display("pwm_period_duty_rescaler verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_duty_write_read();
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'hffff_ffff);
        send_request(pwm_pdr_pkg::FUNC_WRITE_DUTY, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_WRITE_DUTY, 32'h0000_ffff);
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'd0);
        // Only the low half of a wide duty value counts.
        send_request(pwm_pdr_pkg::FUNC_WRITE_DUTY, 32'habcd_8000);
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'd0);
    endtask

    task automatic test_period_prescaler_edges();
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd65535);
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd65536);
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd4194304);
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd67108863);
        // Too long for any prescaler: slowest one, full-scale top.
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'hffff_ffff);
    endtask

    task automatic test_zero_top();
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_WRITE_DUTY, 32'h0000_ffff);
        send_request(pwm_pdr_pkg::FUNC_SET_PULSE, 32'd5);
        send_request(pwm_pdr_pkg::FUNC_READ_DUTY, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_SET_PERIOD, 32'd20000);
    endtask

    task automatic test_pulse_width();
        send_request(pwm_pdr_pkg::FUNC_SET_PULSE, 32'd0);
        send_request(pwm_pdr_pkg::FUNC_SET_PULSE, 32'hffff_ffff);
        send_request(pwm_pdr_pkg::FUNC_SET_PULSE, 32'd1000);
    endtask

    task automatic test_random_traffic(input int count);
        pwm_pdr_pkg::t_func op;
        logic [31:0]        arg;
        for (int k = 0; k < count; k++) begin
            op = pwm_pdr_pkg::t_func'($urandom_range(0, 3));
            case (op)
                pwm_pdr_pkg::FUNC_WRITE_DUTY:
                    arg = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 65535);
                pwm_pdr_pkg::FUNC_SET_PERIOD:
                    arg = ($urandom_range(0, 3) == 0) ? period_near_edge()
                                                      : $urandom >> $urandom_range(0, 31);
                default:
                    arg = $urandom >> $urandom_range(0, 31);
            endcase
            send_request(op, arg);
        end
    endtask

    task automatic test_no_idle_stretch(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        test_random_traffic(count);
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    // The result side holds off long enough for the block to fill up and
    // stall requests while new ones keep being offered.
    task automatic test_output_hold_off(input int count);
        tx_idle_on = 1'b0;
        hold_off_trigger <= hold_off_trigger + 1;
        test_random_traffic(count);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_drain_pause(input int count);
        test_random_traffic(count);
        wait_for_drain();
        test_random_traffic(count);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_duty_write_read();
        test_period_prescaler_edges();
        test_zero_top();
        test_pulse_width();
        test_random_traffic(520);
        test_no_idle_stretch(200);
        test_output_hold_off(16);
        test_drain_pause(20);
        test_random_traffic(520);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("outstanding results", 32'd0, 32'(pending_results.size()));

        $display("Sent %0d requests: %0d duty writes, %0d duty reads, %0d period, %0d pulse.",
                 requests_sent, op_count[pwm_pdr_pkg::FUNC_WRITE_DUTY],
                 op_count[pwm_pdr_pkg::FUNC_READ_DUTY],
                 op_count[pwm_pdr_pkg::FUNC_SET_PERIOD],
                 op_count[pwm_pdr_pkg::FUNC_SET_PULSE]);
        $display("Checked %0d results, including zero top, prescaler edges and back-pressure.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("pwm_period_duty_rescaler verification clean");
        end else begin
            $display("pwm_period_duty_rescaler verification failed");
        end
        $finish;
    end

endmodule

// ----- pwm_period_duty_rescaler.f -----
rtl/pwm_pdr_pkg.sv
rtl/pwm_period_duty_rescaler.sv
bench/pwm_period_duty_rescaler_tb.sv
